FILE: hw/rtl/tremolo_lfo_tap_tempo_macros.svh
// ----------------------------------------------------------------------------
// Tremolo LFO assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TREMOLO_LFO_TAP_TEMPO_MACROS_SVH
`define TREMOLO_LFO_TAP_TEMPO_MACROS_SVH

`define TLT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tremolo LFO assertion failed");

`define TLT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tremolo LFO assertion failed");

`endif

FILE: hw/rtl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// Tremolo LFO package
// Codes, state and tag types shared by the tremolo LFO files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlt_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 1'b1;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_KNOB = 2'd2;

    localparam logic [2:0] WV_COS  = 3'd0;
    localparam logic [2:0] WV_SQR  = 3'd1;
    localparam logic [2:0] WV_TRI  = 3'd2;
    localparam logic [2:0] WV_RUP  = 3'd3;
    localparam logic [2:0] WV_RDN  = 3'd4;
    localparam logic [2:0] WV_GDN  = 3'd5;

    localparam logic [10:0] MIN_PERIOD     = 11'd10;
    localparam logic [10:0] MAX_TAP_PERIOD = 11'd2000;
    localparam logic [10:0] TAP_GAP        = 11'd2000;
    localparam logic [10:0] BLINK_DIV      = 11'd10;
    localparam int MA_W = 17;

    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_SCALE, S_LEVEL, S_MUL, S_DIV, S_FIN, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        TG_AVG, TG_SCALE, TG_BLINK, TG_COSF, TG_COSL,
        TG_TRIDN, TG_TRIUP, TG_RAMPUP, TG_RAMPDN
    } t_tag;

endpackage

`default_nettype wire

FILE: hw/rtl/tlt_in_if.sv
// ----------------------------------------------------------------------------
// Tremolo LFO input channel
// Carries one tick, footswitch edge or knob setting per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       switch_level;
    logic [9:0] knob_period;

    modport source (output valid, output operation, output switch_level,
                    output knob_period, input ready);
    modport sink (input valid, input operation, input switch_level,
                  input knob_period, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tlt_out_if.sv
// ----------------------------------------------------------------------------
// Tremolo LFO result channel
// Carries one level and LED bit per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic       led_on;

    modport source (output valid, output level, output led_on, input ready);
    modport sink (input valid, input level, input led_on, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tlt_cfg_if.sv
// ----------------------------------------------------------------------------
// Tremolo LFO configuration channel
// Carries one register write per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tlt_pkg::CFG_IDX_W-1:0]    index;
    logic [tlt_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tremolo_lfo_tap_tempo.sv
// A divider pass is S_MUL, then S_DIV for NW quotient bits (NW = 22), then S_FIN.
// A tick, plain edge or unused code takes one pass; cosine adds a second multiply in
// S_MUL, square and gate go straight to the output; a knob setting takes three passes,
// and a tap first sums up to TAP_SLOTS stored intervals in S_SUM, then one more pass.
// One item at a time; the next is taken after the result transfer.
// Reset is synchronous and restores period 500, phase 0 and cleared tap history.
// ----------------------------------------------------------------------------
// Tremolo LFO with tap tempo
// Sequencer around one shared multiplier and one restoring serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tremolo_lfo_tap_tempo_macros.svh"

module tremolo_lfo_tap_tempo #(
    parameter int TAP_SLOTS       = 5,
    parameter int MAX_KNOB_PERIOD = 1000,
    parameter int COS_TABLE_DEPTH = 256
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tlt_in_if.sink     i_in,
    tlt_out_if.source  o_out,
    tlt_cfg_if.sink    i_cfg
);

    localparam int IW  = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
    localparam int CW  = $clog2(TAP_SLOTS + 1);
    localparam int AW  = 11 + CW;
    localparam int FW  = $clog2(4 * COS_TABLE_DEPTH);
    localparam int TW  = $clog2(COS_TABLE_DEPTH + 1);
    localparam int MBW = ($clog2(4 * COS_TABLE_DEPTH + 1) > 11) ?
                         $clog2(4 * COS_TABLE_DEPTH + 1) : 11;
    localparam int PW  = tlt_pkg::MA_W + MBW;
    localparam int NW  = (11 + FW > 22) ? 11 + FW : 22;
    localparam int NCW = $clog2(NW);
    localparam logic [10:0] MAX_KNOB = 11'(MAX_KNOB_PERIOD);
    localparam logic [FW:0] D1 = (FW + 1)'(COS_TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TAP_SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TAP_SLOTS);

    function automatic logic [(COS_TABLE_DEPTH+1)*16-1:0] build_cos();
        logic [(COS_TABLE_DEPTH+1)*16-1:0] tab;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] acc;
        logic [63:0] t;
        logic [63:0] part;
        tab = '0;
        for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
            y = (64'(i) * 64'd1686629713) / COS_TABLE_DEPTH;
            y2 = (y * y) >> 30;
            acc = 64'd1073741824;
            for (int k = 0; k < 7; k++) begin
                part = (y2 * acc) >> 30;
                case (k)
                    0: t = part / 64'd182;
                    1: t = part / 64'd132;
                    2: t = part / 64'd90;
                    3: t = part / 64'd56;
                    4: t = part / 64'd30;
                    5: t = part / 64'd12;
                    default: t = part >> 1;
                endcase
                acc = (t >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - t;
            end
            tab[i*16 +: 16] = 16'((acc + 64'd16384) >> 15);
        end
        return tab;
    endfunction

    localparam logic [(COS_TABLE_DEPTH+1)*16-1:0] COS_TAB = build_cos();

    tlt_pkg::t_state r_state, n_state;
    tlt_pkg::t_tag   r_tag, n_tag;
    logic [2:0]  r_wave, n_wave;
    logic [7:0]  r_depth, n_depth;
    logic [10:0] r_phase, n_phase;
    logic [10:0] r_period, n_period;
    logic [9:0]  r_half, n_half;
    logic [7:0]  r_blink, n_blink;
    logic [10:0] r_tap [0:TAP_SLOTS-1];
    logic [10:0] n_tap [0:TAP_SLOTS-1];
    logic [CW-1:0] r_tap_count, n_tap_count;
    logic [IW-1:0] r_tap_next, n_tap_next;
    logic [10:0] r_since, n_since;
    logic        r_sw, n_sw;
    logic [IW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_acc, n_acc;
    logic [10:0] r_newp, n_newp;
    logic [tlt_pkg::MA_W-1:0] r_ma, n_ma;
    logic [MBW-1:0] r_mb, n_mb;
    logic [10:0] r_den, n_den;
    logic [NW-1:0] r_q, n_q;
    logic [10:0] r_rem, n_rem;
    logic [NCW-1:0] r_cnt, n_cnt;
    logic [7:0]  r_level, n_level;

    logic [PW-1:0] prod;
    logic [11:0]   div_t;
    logic [7:0]    span;
    logic [10:0]   knob;
    logic [10:0]   q11;
    logic [FW-1:0] cf;
    logic [1:0]    cq;
    logic [FW:0]   cr;
    logic [TW-1:0] cidx;
    logic [15:0]   cval;
    logic [16:0]   cu;

    assign i_in.ready  = (r_state == tlt_pkg::S_IDLE);
    assign o_out.valid = (r_state == tlt_pkg::S_OUT);
    assign o_out.level = r_level;
    assign o_out.led_on = (r_phase < {3'b000, r_blink});
    assign i_cfg.ready = 1'b1;

    assign prod = PW'(r_ma) * PW'(r_mb);
    assign div_t = {r_rem, r_q[NW-1]};
    assign span = 8'd255 - r_depth;
    assign q11 = r_q[10:0];
    assign cf = r_q[FW-1:0];

    always_comb begin
        if ({1'b0, cf} >= 3 * D1) begin
            cq = 2'd3;
        end else if ({1'b0, cf} >= 2 * D1) begin
            cq = 2'd2;
        end else if ({1'b0, cf} >= D1) begin
            cq = 2'd1;
        end else begin
            cq = 2'd0;
        end
        cr = {1'b0, cf} - (FW + 1)'(cq) * D1;
        cidx = (cq == 2'd0 || cq == 2'd2) ? TW'(cr) : TW'(D1 - cr);
        cval = COS_TAB[{cidx, 4'b0000} +: 16];
        cu = (cq == 2'd0 || cq == 2'd3) ? 17'd32768 + {1'b0, cval}
                                        : 17'd32768 - {1'b0, cval};
    end

    always_comb begin
        knob = {1'b0, i_in.knob_period};
        if (knob < tlt_pkg::MIN_PERIOD) begin
            knob = tlt_pkg::MIN_PERIOD;
        end else if (knob > MAX_KNOB) begin
            knob = MAX_KNOB;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tag = r_tag;
        n_wave = r_wave;
        n_depth = r_depth;
        n_phase = r_phase;
        n_period = r_period;
        n_half = r_half;
        n_blink = r_blink;
        n_tap = r_tap;
        n_tap_count = r_tap_count;
        n_tap_next = r_tap_next;
        n_since = r_since;
        n_sw = r_sw;
        n_idx = r_idx;
        n_acc = r_acc;
        n_newp = r_newp;
        n_ma = r_ma;
        n_mb = r_mb;
        n_den = r_den;
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_level = r_level;

        if (i_cfg.valid) begin
            if (i_cfg.index == tlt_pkg::CFG_WAVE) begin
                n_wave = i_cfg.data[2:0];
            end else begin
                n_depth = i_cfg.data;
            end
        end

        unique case (r_state)
            tlt_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = tlt_pkg::S_LEVEL;
                    case (i_in.operation)
                        tlt_pkg::OP_TICK: begin
                            n_phase = (r_phase + 11'd1 == r_period) ? 11'd0
                                                                    : r_phase + 11'd1;
                            if (r_since <= tlt_pkg::TAP_GAP) begin
                                n_since = r_since + 11'd1;
                            end
                        end
                        tlt_pkg::OP_EDGE: begin
                            if (r_wave >= tlt_pkg::WV_GDN) begin
                                n_sw = ~r_sw;
                            end else if (i_in.switch_level) begin
                                n_since = 11'd0;
                                if (r_since > tlt_pkg::TAP_GAP) begin
                                    n_tap_count = '0;
                                    n_tap_next = '0;
                                end else begin
                                    n_tap[r_tap_next] = r_since;
                                    n_tap_next = (r_tap_next == LAST_SLOT) ? '0
                                                 : r_tap_next + IW'(1);
                                    if (r_tap_count < SLOTS_C) begin
                                        n_tap_count = r_tap_count + CW'(1);
                                    end
                                    n_acc = '0;
                                    n_idx = '0;
                                    n_state = tlt_pkg::S_SUM;
                                end
                            end
                        end
                        tlt_pkg::OP_KNOB: begin
                            n_newp = knob;
                            n_state = tlt_pkg::S_SCALE;
                        end
                        default: begin
                            n_state = tlt_pkg::S_LEVEL;
                        end
                    endcase
                end
            end
            tlt_pkg::S_SUM: begin
                n_acc = r_acc + AW'(r_tap[r_idx]);
                n_idx = r_idx + IW'(1);
                if (CW'(r_idx) + CW'(1) == r_tap_count) begin
                    n_ma = tlt_pkg::MA_W'(n_acc);
                    n_mb = MBW'(1);
                    n_den = 11'(r_tap_count);
                    n_tag = tlt_pkg::TG_AVG;
                    n_state = tlt_pkg::S_MUL;
                end
            end
            tlt_pkg::S_SCALE: begin
                n_ma = tlt_pkg::MA_W'(r_phase);
                n_mb = MBW'(r_newp - 11'd1);
                n_den = r_period - 11'd1;
                n_tag = tlt_pkg::TG_SCALE;
                n_state = tlt_pkg::S_MUL;
            end
            tlt_pkg::S_LEVEL: begin
                n_ma = tlt_pkg::MA_W'(r_phase);
                n_mb = MBW'(span);
                n_den = r_period - 11'd1;
                n_state = tlt_pkg::S_MUL;
                unique case (r_wave)
                    tlt_pkg::WV_COS: begin
                        n_mb = MBW'(4 * COS_TABLE_DEPTH);
                        n_den = r_period;
                        n_tag = tlt_pkg::TG_COSF;
                    end
                    tlt_pkg::WV_SQR: begin
                        n_level = (r_phase < {1'b0, r_half}) ? 8'd255 : r_depth;
                        n_state = tlt_pkg::S_OUT;
                    end
                    tlt_pkg::WV_TRI: begin
                        if (r_phase < {1'b0, r_half}) begin
                            n_den = {1'b0, r_half};
                            n_tag = tlt_pkg::TG_TRIDN;
                        end else if (r_phase <= {1'b0, r_half} + 11'd1) begin
                            n_level = r_depth;
                            n_state = tlt_pkg::S_OUT;
                        end else begin
                            n_ma = tlt_pkg::MA_W'(r_phase - {1'b0, r_half} - 11'd1);
                            n_den = r_period - {1'b0, r_half} - 11'd2;
                            n_tag = tlt_pkg::TG_TRIUP;
                        end
                    end
                    tlt_pkg::WV_RUP: begin
                        n_tag = tlt_pkg::TG_RAMPUP;
                    end
                    tlt_pkg::WV_RDN: begin
                        n_tag = tlt_pkg::TG_RAMPDN;
                    end
                    tlt_pkg::WV_GDN: begin
                        n_level = r_sw ? 8'd255 : 8'd0;
                        n_state = tlt_pkg::S_OUT;
                    end
                    default: begin
                        n_level = r_sw ? 8'd0 : 8'd255;
                        n_state = tlt_pkg::S_OUT;
                    end
                endcase
            end
            tlt_pkg::S_MUL: begin
                n_q = prod[NW-1:0];
                n_rem = '0;
                n_cnt = '0;
                if (r_tag == tlt_pkg::TG_COSL) begin
                    n_level = r_depth + prod[23:16];
                    n_state = tlt_pkg::S_OUT;
                end else begin
                    n_state = tlt_pkg::S_DIV;
                end
            end
            tlt_pkg::S_DIV: begin
                if (div_t >= {1'b0, r_den}) begin
                    n_rem = 11'(div_t - {1'b0, r_den});
                    n_q = {r_q[NW-2:0], 1'b1};
                end else begin
                    n_rem = div_t[10:0];
                    n_q = {r_q[NW-2:0], 1'b0};
                end
                n_cnt = r_cnt + NCW'(1);
                if (r_cnt == NCW'(NW - 1)) begin
                    n_state = tlt_pkg::S_FIN;
                end
            end
            tlt_pkg::S_FIN: begin
                n_state = tlt_pkg::S_OUT;
                unique case (r_tag)
                    tlt_pkg::TG_AVG: begin
                        if (q11 < tlt_pkg::MIN_PERIOD) begin
                            n_newp = tlt_pkg::MIN_PERIOD;
                        end else if (q11 > tlt_pkg::MAX_TAP_PERIOD) begin
                            n_newp = tlt_pkg::MAX_TAP_PERIOD;
                        end else begin
                            n_newp = q11;
                        end
                        n_state = tlt_pkg::S_SCALE;
                    end
                    tlt_pkg::TG_SCALE: begin
                        n_phase = (q11 >= r_newp) ? r_newp - 11'd1 : q11;
                        n_ma = tlt_pkg::MA_W'(r_newp);
                        n_mb = MBW'(1);
                        n_den = tlt_pkg::BLINK_DIV;
                        n_tag = tlt_pkg::TG_BLINK;
                        n_state = tlt_pkg::S_MUL;
                    end
                    tlt_pkg::TG_BLINK: begin
                        n_blink = r_q[7:0];
                        n_half = r_newp[10:1];
                        n_period = r_newp;
                        n_state = tlt_pkg::S_LEVEL;
                    end
                    tlt_pkg::TG_COSF: begin
                        n_ma = cu;
                        n_mb = MBW'(span);
                        n_tag = tlt_pkg::TG_COSL;
                        n_state = tlt_pkg::S_MUL;
                    end
                    tlt_pkg::TG_TRIDN, tlt_pkg::TG_RAMPDN: begin
                        n_level = 8'd255 - r_q[7:0];
                    end
                    default: begin
                        n_level = r_depth + r_q[7:0];
                    end
                endcase
            end
            tlt_pkg::S_OUT: begin
                if (o_out.ready) begin
                    n_state = tlt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlt_pkg::S_IDLE;
            r_wave <= 3'd0;
            r_depth <= 8'd0;
            r_phase <= 11'd0;
            r_period <= 11'd500;
            r_half <= 10'd250;
            r_blink <= 8'd50;
            r_tap_count <= '0;
            r_tap_next <= '0;
            r_since <= 11'd1000;
            r_sw <= 1'b0;
            for (int i = 0; i < TAP_SLOTS; i++) begin
                r_tap[i] <= 11'd0;
            end
        end else begin
            r_state <= n_state;
            r_wave <= n_wave;
            r_depth <= n_depth;
            r_phase <= n_phase;
            r_period <= n_period;
            r_half <= n_half;
            r_blink <= n_blink;
            r_tap_count <= n_tap_count;
            r_tap_next <= n_tap_next;
            r_since <= n_since;
            r_sw <= n_sw;
            r_tap <= n_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_idx <= n_idx;
        r_acc <= n_acc;
        r_newp <= n_newp;
        r_ma <= n_ma;
        r_mb <= n_mb;
        r_den <= n_den;
        r_q <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_level <= n_level;
    end

    `TLT_ASSERT_IMP(a_one_in_flight, o_out.valid, !i_in.ready)
    `TLT_ASSERT_NXT(a_busy_after_take, i_in.valid && i_in.ready, !i_in.ready)
    `TLT_ASSERT_IMP(a_phase_in_period, r_state == tlt_pkg::S_IDLE, r_phase < r_period)
    `TLT_ASSERT_IMP(a_tap_count_max, 1'b1, r_tap_count <= SLOTS_C)

endmodule

`default_nettype wire
